// ===== rtl/bresenham_line_pixel_stepper_top_defines.svh =====
// Assertion macros for the line stepper.
// Included by the top level; assertions vanish when SYNTHESIS is defined.
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_TOP_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BPLS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define BPLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BPLS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define BPLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/bpls_pkg.sv =====
// Shared types, constants and helpers of the line stepper.
// No dependencies.
package bpls_pkg;

  localparam int COORD_BITS_DEF = 8;
  localparam int FIELD_BITS     = 8;
  localparam int COLOR_BITS     = 12;
  localparam int OFFSET_BITS    = 8;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [FIELD_BITS-1:0] start_x;
    logic [FIELD_BITS-1:0] start_y;
    logic [FIELD_BITS-1:0] end_x_in;
    logic [FIELD_BITS-1:0] end_y_in;
    logic [COLOR_BITS-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] column;
    logic [FIELD_BITS-1:0] page;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
  } pixel_t;

  // Width of a decoded command word for a given coordinate width.
  function automatic int cmd_bits(input int cw);
    cmd_bits = 7 * cw + COLOR_BITS + 10;
  endfunction

endpackage

// ===== rtl/bpls_fifo.sv =====
// Two-entry register queue, head always in slot 0.
// Depends on nothing.
module bpls_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          rd,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  logic [1:0]    cnt_r, cnt_nxt;
  logic [DW-1:0] head_r, head_nxt;
  logic [DW-1:0] tail_r, tail_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = head_r;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    case ({do_wr, do_rd})
      2'b10: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd0) head_nxt = wdata;
        else tail_nxt = wdata;
      end
      2'b01: begin
        cnt_nxt  = cnt_r - 2'd1;
        head_nxt = tail_r;
      end
      2'b11: begin
        // advance and refill in one go
        if (cnt_r == 2'd1) head_nxt = wdata;
        else begin
          head_nxt = tail_r;
          tail_nxt = wdata;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

// ===== rtl/bpls_front.sv =====
// Front end: takes input words, sets up line parameters for starts.
// Depends on bpls_pkg.
module bpls_front
  import bpls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CMD_W = cmd_bits(COORD_BITS)
) (
  input  logic             push,
  input  in_item_t         in_item,
  input  logic             cmd_full,
  output logic             cmd_wr,
  output logic [CMD_W-1:0] cmd_data
);

  localparam int CW = COORD_BITS;

  typedef struct packed {
    logic                  is_start;
    logic [CW-1:0]         x0;
    logic [CW-1:0]         y0;
    logic [CW-1:0]         gx;
    logic [CW-1:0]         gy;
    logic [COLOR_BITS-1:0] color;
    logic                  dxn;
    logic                  dyn;
    logic                  xmaj;
    logic                  single;
    logic [CW:0]           dx2;
    logic [CW:0]           dy2;
    logic signed [CW+2:0]  err;
  } bpls_cmd_t;

  bpls_cmd_t     cmd;
  logic [CW+7:0] x0_w, y0_w, gx_w, gy_w;
  logic [CW-1:0] dx, dy;

  // widen to cover both narrower and wider coordinate settings, then cut
  assign x0_w = {{CW{1'b0}}, in_item.start_x};
  assign y0_w = {{CW{1'b0}}, in_item.start_y};
  assign gx_w = {{CW{1'b0}}, in_item.end_x_in};
  assign gy_w = {{CW{1'b0}}, in_item.end_y_in};

  always_comb begin
    cmd.is_start = (in_item.cmd == CMD_START);
    cmd.x0       = x0_w[CW-1:0];
    cmd.y0       = y0_w[CW-1:0];
    cmd.gx       = gx_w[CW-1:0];
    cmd.gy       = gy_w[CW-1:0];
    cmd.color    = in_item.color;
    cmd.dxn      = (cmd.gx < cmd.x0);
    cmd.dyn      = (cmd.gy < cmd.y0);
    dx           = cmd.dxn ? (cmd.x0 - cmd.gx) : (cmd.gx - cmd.x0);
    dy           = cmd.dyn ? (cmd.y0 - cmd.gy) : (cmd.gy - cmd.y0);
    cmd.dx2      = {dx, 1'b0};
    cmd.dy2      = {dy, 1'b0};
    cmd.xmaj     = (dx > dy);
    cmd.single   = (cmd.x0 == cmd.gx) && (cmd.y0 == cmd.gy);
    if (cmd.xmaj) cmd.err = $signed({2'b00, cmd.dy2}) - $signed({3'b000, dx});
    else          cmd.err = $signed({2'b00, cmd.dx2}) - $signed({3'b000, dy});
  end

  assign cmd_wr   = push && !cmd_full;
  assign cmd_data = cmd;

endmodule

// ===== rtl/bpls_back.sv =====
// Back end: holds the line state, steps at most one pixel per command word.
// Depends on bpls_pkg.
module bpls_back
  import bpls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CMD_W = cmd_bits(COORD_BITS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr,
  input  logic [OFFSET_BITS-1:0] cfg_data,
  input  logic [CMD_W-1:0]       cmd_data,
  input  logic                   cmd_empty,
  output logic                   cmd_rd,
  input  logic                   pix_full,
  output logic                   pix_wr,
  output pixel_t                 pix_data
);

  localparam int CW = COORD_BITS;

  typedef struct packed {
    logic                  is_start;
    logic [CW-1:0]         x0;
    logic [CW-1:0]         y0;
    logic [CW-1:0]         gx;
    logic [CW-1:0]         gy;
    logic [COLOR_BITS-1:0] color;
    logic                  dxn;
    logic                  dyn;
    logic                  xmaj;
    logic                  single;
    logic [CW:0]           dx2;
    logic [CW:0]           dy2;
    logic signed [CW+2:0]  err;
  } bpls_cmd_t;

  bpls_cmd_t cmd;

  logic [OFFSET_BITS-1:0] yoff_r;
  logic [CW-1:0]          cx_r, cx_nxt, cy_r, cy_nxt, gx_r, gx_nxt, gy_r, gy_nxt;
  logic [CW:0]            dx2_r, dx2_nxt, dy2_r, dy2_nxt;
  logic signed [CW+2:0]   err_r, err_nxt;
  logic                   dxn_r, dxn_nxt, dyn_r, dyn_nxt, xmaj_r, xmaj_nxt;
  logic                   act_r, act_nxt;
  logic [COLOR_BITS-1:0]  col_r, col_nxt;

  logic                   run, emit, last, err_ge, done;
  logic [CW:0]            mj2, mn2;
  logic [CW-1:0]          off_cw, page_cw;
  logic [CW+7:0]          off_w, colw, pagew;

  function automatic logic [CW-1:0] step(input logic [CW-1:0] v, input logic neg);
    step = neg ? (v - {{(CW-1){1'b0}}, 1'b1}) : (v + {{(CW-1){1'b0}}, 1'b1});
  endfunction

  assign cmd    = cmd_data;
  assign run    = !cmd_empty && !pix_full;
  assign cmd_rd = run;

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    gx_nxt   = gx_r;
    gy_nxt   = gy_r;
    dx2_nxt  = dx2_r;
    dy2_nxt  = dy2_r;
    err_nxt  = err_r;
    dxn_nxt  = dxn_r;
    dyn_nxt  = dyn_r;
    xmaj_nxt = xmaj_r;
    act_nxt  = act_r;
    col_nxt  = col_r;
    emit     = 1'b0;
    last     = 1'b0;
    done     = 1'b0;
    err_ge   = !err_r[CW+2];
    mj2      = xmaj_r ? dx2_r : dy2_r;
    mn2      = xmaj_r ? dy2_r : dx2_r;
    if (cmd.is_start) begin
      // a start drops whatever line was running
      cx_nxt   = cmd.x0;
      cy_nxt   = cmd.y0;
      gx_nxt   = cmd.gx;
      gy_nxt   = cmd.gy;
      dx2_nxt  = cmd.dx2;
      dy2_nxt  = cmd.dy2;
      err_nxt  = cmd.err;
      dxn_nxt  = cmd.dxn;
      dyn_nxt  = cmd.dyn;
      xmaj_nxt = cmd.xmaj;
      col_nxt  = cmd.color;
      act_nxt  = !cmd.single;
      emit     = 1'b1;
      last     = cmd.single;
    end else if (act_r) begin
      err_nxt = err_r + $signed({2'b00, mn2}) - (err_ge ? $signed({2'b00, mj2}) : '0);
      if (xmaj_r) begin
        if (err_ge) cy_nxt = step(cy_r, dyn_r);
        cx_nxt = step(cx_r, dxn_r);
        done   = (cx_nxt == gx_r);
      end else begin
        if (err_ge) cx_nxt = step(cx_r, dxn_r);
        cy_nxt = step(cy_r, dyn_r);
        done   = (cy_nxt == gy_r);
      end
      act_nxt = !done;
      emit    = 1'b1;
      last    = done;
    end
  end

  assign off_w   = {{CW{1'b0}}, yoff_r};
  assign off_cw  = off_w[CW-1:0];
  assign page_cw = cy_nxt + off_cw;
  assign colw    = {8'b0, cx_nxt};
  assign pagew   = {8'b0, page_cw};

  assign pix_wr               = run && emit;
  assign pix_data.column      = colw[FIELD_BITS-1:0];
  assign pix_data.page        = pagew[FIELD_BITS-1:0];
  assign pix_data.pixel_color = col_nxt;
  assign pix_data.last        = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yoff_r <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      gx_r   <= '0;
      gy_r   <= '0;
      dx2_r  <= '0;
      dy2_r  <= '0;
      err_r  <= '0;
      dxn_r  <= 1'b0;
      dyn_r  <= 1'b0;
      xmaj_r <= 1'b0;
      act_r  <= 1'b0;
      col_r  <= '0;
    end else begin
      if (cfg_wr) yoff_r <= cfg_data;
      if (run) begin
        cx_r   <= cx_nxt;
        cy_r   <= cy_nxt;
        gx_r   <= gx_nxt;
        gy_r   <= gy_nxt;
        dx2_r  <= dx2_nxt;
        dy2_r  <= dy2_nxt;
        err_r  <= err_nxt;
        dxn_r  <= dxn_nxt;
        dyn_r  <= dyn_nxt;
        xmaj_r <= xmaj_nxt;
        act_r  <= act_nxt;
        col_r  <= col_nxt;
      end
    end
  end

endmodule

// ===== rtl/bresenham_line_pixel_stepper_top.sv =====
// Bresenham line stepper: input word channel (push/full), pixel word
// channel (empty/pop) and a page offset register port (valid/ready).
// A start word (cmd 0) loads both endpoints and a colour and yields the first
// pixel; each advance word (cmd 1) yields the next pixel until the one marked
// last. An advance while no line runs yields nothing; a start drops any line
// in progress. Endpoints that coincide give one pixel marked last.
// An accepted word is registered in the command queue, then stepped into the
// pixel queue that drives the pixel ports. Throughput: one word per cycle
// while the pixel queue has room; the pixel step is a single add/compare of
// the error term in the back end. Two-entry queues sit before and after the
// stepper, so full rises only once both queues have filled behind a stalled
// receiver; nothing is lost while pop stays low.
// The offset register is always ready; the user must write it only with the
// block idle, which the block does not enforce. Reset (rst_n low, synchronous)
// empties both queues, leaves no line running and clears the offset to zero.
`include "bresenham_line_pixel_stepper_top_defines.svh"
module bresenham_line_pixel_stepper_top
  import bpls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               in_item,
  output logic                   empty,
  input  logic                   pop,
  output pixel_t                 out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [OFFSET_BITS-1:0] cfg_data
);

  localparam int CMD_W = cmd_bits(COORD_BITS);

  logic             cmd_wr, cmd_full, cmd_rd, cmd_empty;
  logic [CMD_W-1:0] cmd_in, cmd_out;
  logic             pix_wr, pix_full;
  pixel_t           pix_in, pix_out;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;
  assign out_item  = pix_out;

  bpls_front #(.COORD_BITS(COORD_BITS)) u_front (
    .push     (push),
    .in_item  (in_item),
    .cmd_full (cmd_full),
    .cmd_wr   (cmd_wr),
    .cmd_data (cmd_in)
  );

  bpls_fifo #(.DW(CMD_W)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (cmd_wr),
    .wdata (cmd_in),
    .full  (cmd_full),
    .rd    (cmd_rd),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  bpls_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_data  (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_rd    (cmd_rd),
    .pix_full  (pix_full),
    .pix_wr    (pix_wr),
    .pix_data  (pix_in)
  );

  bpls_fifo #(.DW($bits(pixel_t))) u_pix_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (pix_wr),
    .wdata (pix_in),
    .full  (pix_full),
    .rd    (pop),
    .rdata (pix_out),
    .empty (empty)
  );

  `BPLS_ASSERT_NEXT(a_word_queued, clk, rst_n, push && !full, !cmd_empty, "accepted word not queued")
  `BPLS_ASSERT_NEVER(a_pix_overflow, clk, rst_n, pix_wr && pix_full, "pixel written to full queue")
  `BPLS_ASSERT_NEVER(a_cmd_underflow, clk, rst_n, cmd_rd && cmd_empty, "command read from empty queue")

endmodule
